>>> rtl/core/bsl_pkg.sv
// ----------------------------------------------------------------------------
// bsl_pkg
// Shared types and constants of the bounded sequential list: request and
// response payloads, action codes and sequencer states.
// ----------------------------------------------------------------------------
package bsl_pkg;

	// default list capacity in entries
	localparam int unsigned CAPACITY_DEF = 16;

	// width of one stored value
	localparam int unsigned VAL_W = 32;

	// action codes carried in a request
	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_FIND   = 2'd1,
		ACT_DELETE = 2'd2
	} action_t;

	// one request: action, 1-based insert position, value
	typedef struct packed {
		logic [1:0]              action;
		logic [4:0]              position;
		logic signed [VAL_W-1:0] value;
	} req_t;

	// one response
	typedef struct packed {
		logic       ok;
		logic [4:0] found_position;
		logic [4:0] list_length;
	} rsp_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_WR,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_DONE
	} state_t;

endpackage

>>> rtl/core/bsl_chan_if.sv
// ----------------------------------------------------------------------------
// bsl_chan_if
// Valid/ready channel carrying one payload of a given type per request.
// ----------------------------------------------------------------------------
interface bsl_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/bsl_ram.sv
// ----------------------------------------------------------------------------
// bsl_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bsl_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/bounded_sequential_list.sv
// Bounded sequential list: packed ordered list of signed 32-bit values in one RAM.
// Insert shifts the entries from the insert position up by one, then writes the value;
// find and delete scan from the first entry to the match; delete then shifts the tail down.
// One request at a time: each walks the single RAM read port entry by entry (read, then
// compare or write), and no new request is taken until the response is issued.
// Reset: arst_n clears the length and control; RAM contents stay undefined until written.
module bounded_sequential_list
	import bsl_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bsl_chan_if.sink   req,
	bsl_chan_if.source rsp
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = ((CW > 5) ? CW : 5) + 1;

	state_t            state_q, state_nxt;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     ptr_q;
	logic [1:0]        act_q;
	logic [PW-1:0]     pos_q;
	logic [VAL_W-1:0]  val_q;
	logic              ok_q;
	logic [4:0]        fpos_q;
	logic              rsp_valid_q;
	rsp_t              rsp_data_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [VAL_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [VAL_W-1:0]  ram_rdata;

	logic [PW-1:0]     cnt_ext;
	logic [PW-1:0]     ptr_ext;
	logic [PW-1:0]     ptr_inc;
	logic [PW-1:0]     ptr_dec;
	logic [PW-1:0]     req_pos_ext;
	logic [PW-1:0]     pos_dec;
	logic              req_fire;
	logic              ins_ok;
	logic              ins_go;
	logic              scan_go;
	logic              match;
	logic              del_go;
	logic              rsp_free;
	logic              is_find;

	// widened views for compares and pointer steps
	assign cnt_ext     = PW'(count_q);
	assign ptr_ext     = PW'(ptr_q);
	assign ptr_inc     = ptr_ext + PW'(1);
	assign ptr_dec     = ptr_ext - PW'(1);
	assign req_pos_ext = PW'(req.data.position);
	assign pos_dec     = pos_q - PW'(1);

	// request acceptance and insert legality
	assign req_fire = req.valid && req.ready;
	assign ins_ok   = (cnt_ext < PW'(CAPACITY)) && (req_pos_ext != '0)
		&& (req_pos_ext <= cnt_ext + PW'(1));

	// loop conditions of the sequencer
	assign ins_go   = (ptr_ext >= pos_q);
	assign scan_go  = (ptr_ext < cnt_ext);
	assign match    = (ram_rdata == val_q);
	assign del_go   = (ptr_inc < cnt_ext);
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign is_find  = (action_t'(act_q) == ACT_FIND);

	// entry storage
	bsl_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					priority case (action_t'(req.data.action))
						ACT_INSERT: state_nxt = ins_ok ? ST_INS_RD : ST_DONE;
						ACT_FIND:   state_nxt = ST_SCAN_RD;
						ACT_DELETE: state_nxt = ST_SCAN_RD;
						default:    state_nxt = ST_DONE;
					endcase
				end
			end
			ST_INS_RD:   state_nxt = ins_go ? ST_INS_WR : ST_DONE;
			ST_INS_WR:   state_nxt = ST_INS_RD;
			ST_SCAN_RD:  state_nxt = scan_go ? ST_SCAN_CMP : ST_DONE;
			ST_SCAN_CMP: begin
				if (!match) begin
					state_nxt = ST_SCAN_RD;
				end else if (is_find) begin
					state_nxt = ST_DONE;
				end else begin
					state_nxt = ST_DEL_RD;
				end
			end
			ST_DEL_RD:   state_nxt = del_go ? ST_DEL_WR : ST_DONE;
			ST_DEL_WR:   state_nxt = ST_DEL_RD;
			ST_DONE:     state_nxt = rsp_free ? ST_IDLE : ST_DONE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	// memory port controls and request ready
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = ptr_q[AW-1:0];
		req.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_INS_RD: begin
				if (ins_go) begin
					ram_re    = 1'b1;
					ram_raddr = ptr_dec[AW-1:0];
				end else begin
					ram_we    = 1'b1;
					ram_waddr = pos_dec[AW-1:0];
					ram_wdata = val_q;
				end
			end
			ST_INS_WR: ram_we = 1'b1;
			ST_SCAN_RD: ram_re = scan_go;
			ST_SCAN_CMP: begin
			end
			ST_DEL_RD: begin
				ram_re    = del_go;
				ram_raddr = ptr_inc[AW-1:0];
			end
			ST_DEL_WR: ram_we = 1'b1;
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// control state: sequencer, list length, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_INS_RD && !ins_go) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == ST_DEL_RD && !del_go) begin
				count_q <= count_q - CW'(1);
			end
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request payload, walk pointer and pending result
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				act_q  <= req.data.action;
				pos_q  <= req_pos_ext;
				val_q  <= req.data.value;
				ok_q   <= 1'b0;
				fpos_q <= '0;
				if (action_t'(req.data.action) == ACT_INSERT) begin
					ptr_q <= count_q;
				end else begin
					ptr_q <= '0;
				end
			end
			ST_INS_RD: ok_q <= !ins_go;
			ST_INS_WR: ptr_q <= ptr_dec[CW-1:0];
			ST_SCAN_RD: begin
			end
			ST_SCAN_CMP: begin
				if (match) begin
					ok_q   <= 1'b1;
					fpos_q <= ptr_inc[4:0];
				end else begin
					ptr_q <= ptr_inc[CW-1:0];
				end
			end
			ST_DEL_RD: begin
			end
			ST_DEL_WR: ptr_q <= ptr_inc[CW-1:0];
			ST_DONE: begin
				if (rsp_free) begin
					rsp_data_q.ok             <= ok_q;
					rsp_data_q.found_position <= fpos_q;
					rsp_data_q.list_length    <= cnt_ext[4:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule
